[rtl/core/wcf_pkg.sv]
// wcf_pkg: shared types, character codes and request codes of the word censor filter
// no dependencies; imported by the filter sequencer and its output stage

package wcf_pkg;

  // request codes carried by in_req_type
  localparam logic [1:0] REQ_CHAR = 2'd0;
  localparam logic [1:0] REQ_LEN  = 2'd1;
  localparam logic [1:0] REQ_TEXT = 2'd2;

  // character codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_SHIFT = 8'h20;

  // a censored word goes out as this many asterisks
  localparam int STAR_COUNT = 5;

  // one result word and its end-of-item mark
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic is_upper;
    is_upper = (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
    return is_upper ? (c + CASE_SHIFT) : c;
  endfunction

endpackage

[rtl/core/wcf_ram.sv]
// wcf_ram: generic simple dual-port ram, one write and one registered read per cycle
// no dependencies; used for the dictionary, the entry lengths and the word buffer

module wcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/wcf_out_stage.sv]
// wcf_out_stage: result register between the sequencer and the receiver
// depends on wcf_pkg for out_word_t

module wcf_out_stage
  import wcf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_word_t word,
  output logic      free,
  output logic      out_valid,
  input  logic      out_stall,
  output logic [7:0] out_byte,
  output logic      out_last
);

  logic      valid_r, valid_nxt;
  out_word_t word_r;

  // slot can take a word if empty or being drained this cycle
  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= word;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = word_r.data;
  assign out_last  = word_r.last;

endmodule

[rtl/core/word_censor_filter.sv]
// word_censor_filter: top level, item sequencer with dictionary search and word emission
// depends on wcf_pkg, wcf_ram (three instances) and wcf_out_stage
//
// usage
//   input channel in_*: one item per accepted word (in_valid high, in_stall low).
//   in_req_type selects a dictionary character write, an entry length write or a
//   stream text byte. load items give no results. text bytes are gathered into
//   words; a delimiter, '<' or end of stream runs a dictionary search and sends the
//   word out, or five asterisks on a hit.
//   result channel out_*: out_byte words, out_last marks the final one of an item.
//   a single output register parts the two sides; out_stall holds it and the
//   sequencer waits on it, nothing is dropped.
//   cfg channel: cfg_active_entries sets how many entries (from entry zero) are
//   searched; always ready, write it only while no item is in flight.
// flush sequence
//   a flush starts, then reads the length of each searched entry and compares,
//   character by character, each entry whose length equals the word length,
//   then emits the bytes, holding while out_stall is high; the dictionary read
//   port is the limiting resource.
// reset
//   rst_n is synchronous. after reset a clearing pass writes zero to every entry
//   length with in_stall high; cfg writes are still taken.

module word_censor_filter
  import wcf_pkg::*;
#(
  parameter int NUM_ENTRIES  = 256,
  parameter int MAX_WORD_LEN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  // item input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_entry_index,
  input  logic [4:0] in_char_pos,
  input  logic [5:0] in_entry_len,
  input  logic [7:0] in_byte_value,
  input  logic       in_end_of_stream,
  // result output
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_active_entries
);

  // entry index bits, entry counter bits (holds NUM_ENTRIES), char index bits,
  // word count bits (holds MAX_WORD_LEN)
  localparam int EW  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int ECW = $clog2(NUM_ENTRIES + 1);
  localparam int CW  = $clog2(MAX_WORD_LEN);
  localparam int WCW = $clog2(MAX_WORD_LEN + 1);
  localparam int LW  = (ECW > 9) ? ECW : 9;
  // ram depths chosen so the address is {entry, char} with no multiply
  localparam int LEN_DEPTH  = (NUM_ENTRIES > 1) ? NUM_ENTRIES : 2;
  localparam int DICT_DEPTH = LEN_DEPTH * (2 ** CW);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_FLUSH = 7'b0000100,
    S_LEN   = 7'b0001000,
    S_CHR   = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_BYTE  = 7'b1000000
  } state_t;

  // what follows when the current flush or emission is done
  typedef enum logic [3:0] {
    ST_PRE  = 4'b0001,  // flush before a delimiter or '<'
    ST_FULL = 4'b0010,  // raw dump of a full buffer, then the byte
    ST_EOS  = 4'b0100,  // end of stream flush
    ST_DONE = 4'b1000   // nothing left
  } step_t;

  state_t           state_r, state_nxt;
  step_t            step_r, step_nxt;
  logic [WCW-1:0]   wc_r, wc_nxt;
  logic             ov_r, ov_nxt;
  logic [8:0]       act_r, act_nxt;
  logic [ECW-1:0]   e_r, e_nxt;
  logic [WCW-1:0]   k_r, k_nxt;
  logic [WCW-1:0]   em_cnt_r, em_cnt_nxt;
  logic             em_star_r, em_star_nxt;
  logic             em_last_r, em_last_nxt;
  logic [7:0]       cur_byte_r, cur_byte_nxt;
  logic             cur_eos_r, cur_eos_nxt;
  logic             cur_lt_r, cur_lt_nxt;

  // ram ports
  logic             len_we, len_re;
  logic [EW-1:0]    len_waddr, len_raddr;
  logic [5:0]       len_wdata, len_rdata;
  logic             dict_we, dict_re;
  logic [EW+CW-1:0] dict_waddr, dict_raddr;
  logic [7:0]       dict_rdata;
  logic             buf_we, buf_re;
  logic [CW-1:0]    buf_waddr, buf_raddr;
  logic [7:0]       buf_wdata, buf_rdata;

  // output stage
  logic             out_load, out_free;
  out_word_t        out_word;

  logic             in_take;
  logic             is_delim, is_lt;
  logic [ECW-1:0]   e_inc;
  logic [WCW-1:0]   k_inc;
  logic             more;
  logic             len_hit, chr_hit;
  logic             go_next, go_emit, go_star, fin;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign is_delim = (in_byte_value == CH_SPACE) || (in_byte_value == CH_NUL) ||
                    (in_byte_value == CH_CR) || (in_byte_value == CH_LF);
  assign is_lt    = (in_byte_value == CH_LT);

  assign e_inc = e_r + 1'b1;
  assign k_inc = k_r + 1'b1;
  // another entry left inside both the configured count and the table
  assign more  = (e_inc < ECW'(NUM_ENTRIES)) && (LW'(e_inc) < LW'(act_r));

  assign len_hit = (len_rdata != 6'd0) && (len_rdata == 6'(wc_r));
  assign chr_hit = (dict_rdata == to_lower(buf_rdata));

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    wc_nxt       = wc_r;
    ov_nxt       = ov_r;
    act_nxt      = act_r;
    e_nxt        = e_r;
    k_nxt        = k_r;
    em_cnt_nxt   = em_cnt_r;
    em_star_nxt  = em_star_r;
    em_last_nxt  = em_last_r;
    cur_byte_nxt = cur_byte_r;
    cur_eos_nxt  = cur_eos_r;
    cur_lt_nxt   = cur_lt_r;

    len_we     = 1'b0;
    len_waddr  = EW'(in_entry_index);
    len_wdata  = in_entry_len;
    len_re     = 1'b0;
    len_raddr  = e_r[EW-1:0];
    dict_we    = 1'b0;
    dict_waddr = {EW'(in_entry_index), CW'(in_char_pos)};
    dict_re    = 1'b0;
    dict_raddr = {e_r[EW-1:0], k_r[CW-1:0]};
    buf_we     = 1'b0;
    buf_waddr  = wc_r[CW-1:0];
    buf_wdata  = in_byte_value;
    buf_re     = 1'b0;
    buf_raddr  = k_r[CW-1:0];

    out_load      = 1'b0;
    out_word.data = cur_byte_r;
    out_word.last = 1'b1;

    go_next = 1'b0;
    go_emit = 1'b0;
    go_star = 1'b0;
    fin     = 1'b0;

    if (cfg_valid && cfg_ready) begin
      act_nxt = cfg_active_entries;
    end

    case (state_r)
      S_CLEAR: begin
        len_we    = 1'b1;
        len_waddr = e_r[EW-1:0];
        len_wdata = 6'd0;
        if (e_r == ECW'(NUM_ENTRIES - 1)) begin
          e_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          e_nxt = e_inc;
        end
      end

      S_IDLE: begin
        if (in_take) begin
          case (in_req_type)
            REQ_CHAR: begin
              if ((32'(in_entry_index) < NUM_ENTRIES) &&
                  (32'(in_char_pos) < MAX_WORD_LEN)) begin
                dict_we = 1'b1;
              end
            end
            REQ_LEN: begin
              if (32'(in_entry_index) < NUM_ENTRIES) begin
                len_we = 1'b1;
              end
            end
            REQ_TEXT: begin
              cur_byte_nxt = in_byte_value;
              cur_eos_nxt  = in_end_of_stream;
              cur_lt_nxt   = is_lt;
              if (is_delim || is_lt) begin
                // delimiter follows, so only a '<' not at end of stream ends the item
                step_nxt    = ST_PRE;
                em_last_nxt = is_lt && !in_end_of_stream;
                state_nxt   = S_FLUSH;
              end else if (ov_r) begin
                // overflowed word: byte passes straight through
                step_nxt  = ST_DONE;
                ov_nxt    = !in_end_of_stream;
                state_nxt = S_BYTE;
              end else if (wc_r < WCW'(MAX_WORD_LEN)) begin
                buf_we = 1'b1;
                wc_nxt = wc_r + 1'b1;
                if (in_end_of_stream) begin
                  step_nxt    = ST_EOS;
                  em_last_nxt = 1'b1;
                  state_nxt   = S_FLUSH;
                end
              end else begin
                // buffer full: dump it unchanged, then this byte
                em_star_nxt = 1'b0;
                em_cnt_nxt  = wc_r;
                em_last_nxt = 1'b0;
                k_nxt       = '0;
                buf_re      = 1'b1;
                buf_raddr   = '0;
                step_nxt    = ST_FULL;
                wc_nxt      = '0;
                ov_nxt      = !in_end_of_stream;
                state_nxt   = S_EMIT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_FLUSH: begin
        if (wc_r == '0) begin
          fin = 1'b1;
        end else if (act_r == 9'd0) begin
          go_emit = 1'b1;
        end else begin
          e_nxt     = '0;
          len_re    = 1'b1;
          len_raddr = '0;
          state_nxt = S_LEN;
        end
      end

      S_LEN: begin
        if (len_hit) begin
          k_nxt      = '0;
          dict_re    = 1'b1;
          dict_raddr = {e_r[EW-1:0], CW'(0)};
          buf_re     = 1'b1;
          buf_raddr  = '0;
          state_nxt  = S_CHR;
        end else begin
          go_next = 1'b1;
        end
      end

      S_CHR: begin
        if (chr_hit) begin
          if (k_inc == wc_r) begin
            go_emit = 1'b1;
            go_star = 1'b1;
          end else begin
            k_nxt      = k_inc;
            dict_re    = 1'b1;
            dict_raddr = {e_r[EW-1:0], k_inc[CW-1:0]};
            buf_re     = 1'b1;
            buf_raddr  = k_inc[CW-1:0];
          end
        end else begin
          go_next = 1'b1;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_word.data = em_star_r ? CH_STAR : buf_rdata;
          out_word.last = (k_inc == em_cnt_r) && em_last_r;
          if (k_inc == em_cnt_r) begin
            fin = 1'b1;
          end else begin
            k_nxt     = k_inc;
            buf_re    = 1'b1;
            buf_raddr = k_inc[CW-1:0];
          end
        end
      end

      S_BYTE: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_word.data = cur_byte_r;
          out_word.last = 1'b1;
          fin           = 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // step to the next entry, or give up with no match
    if (go_next) begin
      if (more) begin
        e_nxt     = e_inc;
        len_re    = 1'b1;
        len_raddr = e_inc[EW-1:0];
        state_nxt = S_LEN;
      end else begin
        go_emit = 1'b1;
      end
    end

    // start sending the word or the asterisks; first buffer byte is read here
    if (go_emit) begin
      em_star_nxt = go_star;
      em_cnt_nxt  = go_star ? WCW'(STAR_COUNT) : wc_r;
      k_nxt       = '0;
      buf_re      = 1'b1;
      buf_raddr   = '0;
      state_nxt   = S_EMIT;
    end

    if (fin) begin
      case (step_r)
        ST_PRE: begin
          wc_nxt = '0;
          ov_nxt = 1'b0;
          if (!cur_lt_r) begin
            step_nxt  = ST_DONE;
            state_nxt = S_BYTE;
          end else begin
            // '<' opens the next word
            buf_we    = 1'b1;
            buf_waddr = '0;
            buf_wdata = CH_LT;
            wc_nxt    = WCW'(1);
            if (cur_eos_r) begin
              step_nxt    = ST_EOS;
              em_last_nxt = 1'b1;
              state_nxt   = S_FLUSH;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
        ST_FULL: begin
          step_nxt  = ST_DONE;
          state_nxt = S_BYTE;
        end
        ST_EOS: begin
          wc_nxt    = '0;
          ov_nxt    = 1'b0;
          state_nxt = S_IDLE;
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      step_r  <= ST_DONE;
      wc_r    <= '0;
      ov_r    <= 1'b0;
      act_r   <= 9'd0;
      e_r     <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      wc_r    <= wc_nxt;
      ov_r    <= ov_nxt;
      act_r   <= act_nxt;
      e_r     <= e_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    em_cnt_r   <= em_cnt_nxt;
    em_star_r  <= em_star_nxt;
    em_last_r  <= em_last_nxt;
    cur_byte_r <= cur_byte_nxt;
    cur_eos_r  <= cur_eos_nxt;
    cur_lt_r   <= cur_lt_nxt;
  end

  // entry lengths, cleared by the pass after reset
  wcf_ram #(
    .WIDTH (6),
    .DEPTH (LEN_DEPTH)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .re    (len_re),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

  // dictionary characters, one row per entry
  wcf_ram #(
    .WIDTH (8),
    .DEPTH (DICT_DEPTH)
  ) u_dict_ram (
    .clk   (clk),
    .we    (dict_we),
    .waddr (dict_waddr),
    .wdata (in_byte_value),
    .re    (dict_re),
    .raddr (dict_raddr),
    .rdata (dict_rdata)
  );

  // pending word, original case
  wcf_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WORD_LEN)
  ) u_buf_ram (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .re    (buf_re),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  wcf_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (out_load),
    .word      (out_word),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  // an overflowed word holds nothing in the buffer
  a_ov_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (wc_r == '0))
    else $error("overflow flag set with a buffered word");

  // the output register is only loaded when it can take a word
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("output register overwritten");

  // a search only runs on a non-empty word
  a_search_word: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_LEN) || (state_r == S_CHR)) |-> (wc_r != '0))
    else $error("search on an empty word");

  // character compare stays inside the word
  a_chr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHR) |-> (k_r < wc_r))
    else $error("character index beyond word");

  // load items finish in the cycle they are taken
  a_load_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && ((in_req_type == REQ_CHAR) || (in_req_type == REQ_LEN)))
      |=> (state_r == S_IDLE))
    else $error("load item left the idle state");

endmodule

[bench/word_censor_filter_test.sv]
`timescale 1ns / 1ps
// word_censor_filter_test: self-checking bench for the word censor filter
// depends on wcf_pkg and word_censor_filter; predicts every output word in-line

module word_censor_filter_test
  import wcf_pkg::*;
;

  localparam int ENTRIES      = 256;
  localparam int WORD_MAX     = 32;
  localparam int QUIET_CYCLES = 64;    // block finishes a trailing load or byte well within this
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  typedef logic [7:0] byte_q_t[$];

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // block ports, inputs known from time zero
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_req_type = REQ_TEXT;
  logic [7:0] in_entry_index = '0;
  logic [4:0] in_char_pos = '0;
  logic [5:0] in_entry_len = '0;
  logic [7:0] in_byte_value = '0;
  logic       in_end_of_stream = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [8:0] cfg_active_entries = '0;

  word_censor_filter #(
    .NUM_ENTRIES (ENTRIES),
    .MAX_WORD_LEN(WORD_MAX)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_entry_index    (in_entry_index),
    .in_char_pos       (in_char_pos),
    .in_entry_len      (in_entry_len),
    .in_byte_value     (in_byte_value),
    .in_end_of_stream  (in_end_of_stream),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_active_entries(cfg_active_entries)
  );

  // traffic shaping knobs, percent per cycle
  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_on       = 1'b0;   // forced receiver hold-off
  int items_sent    = 0;      // words accepted that the block acts on
  int errors        = 0;

  // ---------------------------------------------------------------------------
  // filter model: own copy of dictionary, word buffer and entry limit
  // ---------------------------------------------------------------------------
  logic [7:0] dict_mem [ENTRIES][WORD_MAX];
  bit         dict_wr  [ENTRIES][WORD_MAX];   // character ever written
  logic [5:0] dict_len [ENTRIES];
  logic [7:0] wbuf [WORD_MAX];
  int         wcount = 0;
  bit         wovf = 1'b0;
  logic [8:0] active = '0;

  logic [7:0] step_out[$];        // bytes produced by the word being predicted
  out_word_t  filtered_q[$];      // filtered text still owed by the block

  initial begin
    foreach (dict_len[e]) dict_len[e] = '0;
  end

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return c + CASE_SHIFT;
    return c;
  endfunction

  // search entries below the limit for one whose length and lowered text agree
  function automatic bit word_hits();
    int lim, e, k;
    bit same;
    lim = (active < ENTRIES) ? int'(active) : ENTRIES;
    for (e = 0; e < lim; e++) begin
      if (dict_len[e] != 0 && int'(dict_len[e]) == wcount) begin
        same = 1'b1;
        for (k = 0; k < wcount; k++)
          if (dict_mem[e][k] != fold_case(wbuf[k])) same = 1'b0;
        if (same) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // end of a word: asterisks on a hit, the word as typed otherwise
  function automatic void close_word();
    int k;
    if (wcount != 0) begin
      if (word_hits()) begin
        for (k = 0; k < STAR_COUNT; k++) step_out.push_back(CH_STAR);
      end else begin
        for (k = 0; k < wcount; k++) step_out.push_back(wbuf[k]);
      end
    end
    wcount = 0;
    wovf = 1'b0;
  endfunction

  function automatic void predict_filtered(input logic [1:0] req, input logic [7:0] idx,
                                           input logic [4:0] pos, input logic [5:0] len,
                                           input logic [7:0] b, input bit eos);
    int k;
    out_word_t w;
    step_out.delete();
    case (req)
      REQ_CHAR: begin
        dict_mem[idx][pos] = b;
        dict_wr[idx][pos] = 1'b1;
      end
      REQ_LEN: dict_len[idx] = len;
      REQ_TEXT: begin
        if (b == CH_SPACE || b == CH_NUL || b == CH_CR || b == CH_LF) begin
          close_word();
          step_out.push_back(b);
        end else if (b == CH_LT) begin
          // '<' closes the pending word and opens the next one
          close_word();
          wbuf[0] = b;
          wcount = 1;
        end else if (wovf) begin
          step_out.push_back(b);
        end else if (wcount < WORD_MAX) begin
          wbuf[wcount] = b;
          wcount++;
        end else begin
          // buffer full: dump it with this byte, rest of the word passes through
          for (k = 0; k < wcount; k++) step_out.push_back(wbuf[k]);
          step_out.push_back(b);
          wcount = 0;
          wovf = 1'b1;
        end
        if (eos) close_word();
      end
      default: ;
    endcase
    foreach (step_out[i]) begin
      w.data = step_out[i];
      w.last = (i == step_out.size() - 1);
      filtered_q.push_back(w);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: random stall plus forced hold-off, and the output checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= hold_on || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (filtered_q.size() == 0) begin
        $error("out_byte: expected none actual %0h", out_byte);
        errors++;
      end else begin
        want = filtered_q.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte: expected %0h actual %0h", want.data, out_byte);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %0b actual %0b", want.last, out_last);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one word, hold it until taken, then predict what it produces
  task automatic send_item(input logic [1:0] req, input logic [7:0] idx, input logic [4:0] pos,
                           input logic [5:0] len, input logic [7:0] b, input bit eos);
    // random idle cycles ahead of the word
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= req;
    in_entry_index   <= idx;
    in_char_pos      <= pos;
    in_entry_len     <= len;
    in_byte_value    <= b;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_filtered(req, idx, pos, len, b, eos);
    if (req != REQ_UNUSED) items_sent++;
  endtask

  // text bytes carry random junk in the load-only fields
  task automatic send_bytes(input byte_q_t q, input bit eos_last);
    foreach (q[i])
      send_item(REQ_TEXT, 8'($urandom), 5'($urandom), 6'($urandom), q[i],
                eos_last && (i == q.size() - 1));
  endtask

  // write every character of an entry, then its length
  task automatic load_entry(input logic [7:0] e, input byte_q_t q);
    foreach (q[k]) send_item(REQ_CHAR, e, 5'(k), 6'($urandom), q[k], 1'($urandom));
    send_item(REQ_LEN, e, 5'($urandom), 6'(q.size()), 8'($urandom), 1'($urandom));
  endtask

  function automatic byte_q_t to_bytes(input string s);
    byte_q_t q;
    for (int k = 0; k < s.len(); k++) q.push_back(s[k]);
    return q;
  endfunction

  function automatic logic [7:0] pick_delim();
    case ($urandom_range(4))
      0: return CH_SPACE;
      1: return CH_NUL;
      2: return CH_CR;
      3: return CH_LF;
      default: return CH_LT;
    endcase
  endfunction

  // sender pause: nothing owed, then let a trailing load settle
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_active_entries(input logic [8:0] v);
    cfg_active_entries <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    active = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one random stimulus step, mostly whole words with a delimiter
  task automatic random_action();
    byte_q_t    w;
    int         pick, n, e, k, l;
    logic [7:0] c;
    bit         eos_end;
    pick = $urandom_range(99);
    eos_end = ($urandom_range(99) < 15);
    if (pick < 50) begin
      // dictionary word in random case, or letters when the entry is off
      e = $urandom_range(15);
      if (dict_len[e] >= 1 && dict_len[e] <= WORD_MAX) begin
        for (k = 0; k < dict_len[e]; k++) begin
          c = dict_mem[e][k];
          if (c >= CH_LOWER_A && c <= CH_LOWER_Z && $urandom_range(1)) c = c - CASE_SHIFT;
          w.push_back(c);
        end
      end else begin
        n = $urandom_range(1, 5);
        for (k = 0; k < n; k++) w.push_back(8'(CH_LOWER_A + $urandom_range(25)));
      end
      if (!eos_end) w.push_back(pick_delim());
      send_bytes(w, eos_end);
    end else if (pick < 70) begin
      // arbitrary bytes, delimiters may land anywhere
      n = $urandom_range(1, 8);
      for (k = 0; k < n; k++)
        w.push_back(8'(($urandom_range(99) < 70) ? CH_LOWER_A + $urandom_range(25) : $urandom));
      if (!eos_end) w.push_back(pick_delim());
      send_bytes(w, eos_end);
    end else if (pick < 75) begin
      // near or past the buffer size: exact fit and overflow
      n = $urandom_range(30, 40);
      for (k = 0; k < n; k++) w.push_back(8'(CH_LOWER_A + $urandom_range(25)));
      if (!eos_end) w.push_back(pick_delim());
      send_bytes(w, eos_end);
    end else if (pick < 87) begin
      // fresh dictionary entry, now and then with an upper-case letter
      e = ($urandom_range(9) == 0) ? (($urandom_range(1) != 0) ? 255 : 128) : $urandom_range(15);
      n = ($urandom_range(99) < 80) ? $urandom_range(1, 6) : $urandom_range(1, WORD_MAX);
      for (k = 0; k < n; k++) w.push_back(8'(CH_LOWER_A + $urandom_range(25)));
      if ($urandom_range(9) == 0) w[$urandom_range(n - 1)] = 8'(CH_UPPER_A + $urandom_range(25));
      load_entry(8'(e), w);
    end else if (pick < 92) begin
      // length change; only over characters already written
      e = $urandom_range(15);
      l = $urandom_range(WORD_MAX);
      for (k = 0; k < l; k++) if (!dict_wr[e][k]) l = 0;
      send_item(REQ_LEN, 8'(e), 5'($urandom), 6'(l), 8'($urandom), 1'($urandom));
    end else if (pick < 95) begin
      send_item(REQ_CHAR, 8'($urandom), 5'($urandom), 6'($urandom), 8'($urandom),
                1'($urandom));
    end else if (pick < 97) begin
      send_item(REQ_UNUSED, 8'($urandom), 5'($urandom), 6'($urandom), 8'($urandom),
                1'($urandom));
    end else begin
      send_item(REQ_TEXT, 8'($urandom), 5'($urandom), 6'($urandom), 8'($urandom),
                1'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // dictionary loads, including ignored and never-matching cases
  task automatic test_directed_loads();
    write_active_entries(9'd256);
    load_entry(8'd0, to_bytes("cat"));
    load_entry(8'd255, to_bytes("Ok"));     // upper-case entry never matches
    // entry longer than the word buffer: stored, never compared
    send_item(REQ_LEN, 8'd9, 5'd31, 6'd40, 8'hFF, 1'b1);
    // unused request code, end of stream set
    send_item(REQ_UNUSED, 8'd0, 5'd0, 6'd0, CH_SPACE, 1'b1);
  endtask

  // word boundaries, case folding, '<' and end of stream
  task automatic test_directed_text();
    send_bytes(to_bytes("CAt "), 1'b0);      // censored, mixed case
    send_bytes(to_bytes("Ok<"), 1'b0);       // upper-case entry misses; '<' opens a word
    send_item(REQ_TEXT, 8'd0, 5'd0, 6'd0, CH_NUL, 1'b0);
    send_bytes(to_bytes("cat"), 1'b1);       // flushed by end of stream
    send_item(REQ_TEXT, 8'hFF, 5'h1F, 6'h3F, CH_CR, 1'b1);  // empty word flush
    send_item(REQ_TEXT, 8'd0, 5'd0, 6'd0, 8'hFF, 1'b1);
    send_item(REQ_TEXT, 8'd0, 5'd0, 6'd0, CH_LF, 1'b0);
  endtask

  task automatic run_phase(input int idle, input int stall, input logic [8:0] limit,
                           input int count);
    int target;
    wait_for_quiet();
    write_active_entries(limit);
    send_idle_pct = idle;
    stall_pct = stall;
    target = items_sent + count;
    while (items_sent < target) random_action();
  endtask

  // random traffic under each idling pattern and entry limit
  task automatic test_random_traffic();
    run_phase(0, 0, 9'd256, 80);
    run_phase(88, 0, 9'd16, 70);
    run_phase(0, 88, 9'd0, 70);
    run_phase(13, 13, 9'($urandom_range(1, 255)), 70);
  endtask

  // receiver holds off long enough that the block backs up into its input
  task automatic test_output_hold_off();
    byte_q_t w;
    int      k;
    wait_for_quiet();
    write_active_entries(9'd1);
    send_idle_pct = 0;
    stall_pct = 0;
    @(negedge clk);
    hold_on = 1'b1;
    fork
      begin
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_on = 1'b0;
      end
    join_none
    @(posedge clk);
    for (k = 0; k < 12; k++) begin
      w.delete();
      w.push_back(8'(CH_LOWER_A + $urandom_range(25)));
      w.push_back(8'(CH_LOWER_A + $urandom_range(25)));
      w.push_back(pick_delim());
      send_bytes(w, 1'b0);
    end
  endtask

  initial begin
    // reset applied once, at the start
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_loads();
    test_directed_text();
    test_random_traffic();
    test_output_hold_off();

    wait_for_quiet();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[word_censor_filter.f]
rtl/core/wcf_pkg.sv
rtl/core/wcf_ram.sv
rtl/core/wcf_out_stage.sv
rtl/core/word_censor_filter.sv
bench/word_censor_filter_test.sv
